>>> rtl/core/chrl_pkg.sv
// shared constants, word types and hash functions of the hash ring lookup
// used by chrl_ring and consistent_hash_ring_lookup; no dependencies
package chrl_pkg;

   localparam int RING_DEPTH   = 1024;
   localparam int SERVER_SLOTS = 16;
   localparam int IDX_W        = $clog2(RING_DEPTH);
   localparam int CNT_W        = $clog2(RING_DEPTH + 1);
   localparam int SERVER_W     = $clog2(SERVER_SLOTS);
   localparam int HASH_W       = 32;
   localparam int BYTE_W       = 8;
   localparam int REQ_W        = 2;

   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_KEY   = 2'd2;

   localparam logic STATUS_FOUND = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   localparam int MIX_SHL = 10;
   localparam int MIX_SHR = 6;
   localparam int FIN_SHL_A = 3;
   localparam int FIN_SHR = 11;
   localparam int FIN_SHL_B = 15;

   typedef struct packed {
      logic                clear;
      logic                load;
      logic [HASH_W-1:0]   value;
      logic [SERVER_W-1:0] server;
   } ring_cmd_type;

   function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] t;
      t = h + {{(HASH_W - BYTE_W){1'b0}}, b};
      t = t + (t << MIX_SHL);
      t = t ^ (t >> MIX_SHR);
      return t;
   endfunction

   function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] t;
      t = h + (h << FIN_SHL_A);
      t = t ^ (t >> FIN_SHR);
      t = t + (t << FIN_SHL_B);
      return t;
   endfunction

endpackage

>>> rtl/core/chrl_ring.sv
// ring point store: value and server memories, fill count, capacity check
// depends on chrl_pkg
module chrl_ring (
   input  logic                           clock,
   input  logic                           reset,
   input  chrl_pkg::ring_cmd_type         cmd,
   input  logic [chrl_pkg::IDX_W-1:0]     rd_addr,
   output logic [chrl_pkg::HASH_W-1:0]    rd_value,
   output logic [chrl_pkg::SERVER_W-1:0]  rd_server,
   output logic [chrl_pkg::CNT_W-1:0]     count
);

   logic [chrl_pkg::HASH_W-1:0]   value_mem_ff  [chrl_pkg::RING_DEPTH];
   logic [chrl_pkg::SERVER_W-1:0] server_mem_ff [chrl_pkg::RING_DEPTH];
   logic [chrl_pkg::HASH_W-1:0]   rd_value_ff;
   logic [chrl_pkg::SERVER_W-1:0] rd_server_ff;
   logic [chrl_pkg::CNT_W-1:0]    count_ff;
   logic [chrl_pkg::CNT_W-1:0]    count_in;
   logic                          full;
   logic                          wr_en;

   assign full  = (count_ff == chrl_pkg::CNT_W'(chrl_pkg::RING_DEPTH));
   assign wr_en = cmd.load && !full;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + chrl_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem_ff[count_ff[chrl_pkg::IDX_W-1:0]]  <= cmd.value;
         server_mem_ff[count_ff[chrl_pkg::IDX_W-1:0]] <= cmd.server;
      end
      rd_value_ff  <= value_mem_ff[rd_addr];
      rd_server_ff <= server_mem_ff[rd_addr];
   end

   assign rd_value  = rd_value_ff;
   assign rd_server = rd_server_ff;
   assign count     = count_ff;

endmodule

>>> rtl/core/consistent_hash_ring_lookup.sv
// top level of the consistent-hash ring lookup engine
// depends on chrl_pkg and chrl_ring
//
// Clear, load and non-final key words are accepted in the idle state, which
// the block does not leave for them, so another request can follow. A final
// key word is mixed on acceptance, then the hash is finalized, then a binary
// search runs over the ring memory (one probe and compare step per bit of the
// point count, at most 11 for a full ring of 1024 points) and the server is read.
// The registered read of the ring memory sets the step time. The input is
// not ready during the lookup; a result waits in an output register while
// clears, loads and key words keep flowing. Loads beyond capacity are
// dropped; a lookup on an empty ring returns status 1 and server 0.
module consistent_hash_ring_lookup (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [chrl_pkg::REQ_W-1:0]    req_type,
   input  logic [chrl_pkg::HASH_W-1:0]   req_point_value,
   input  logic [chrl_pkg::SERVER_W-1:0] req_point_server,
   input  logic [chrl_pkg::BYTE_W-1:0]   req_key_byte,
   input  logic                          req_key_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [chrl_pkg::SERVER_W-1:0] rsp_server_id,
   output logic [chrl_pkg::HASH_W-1:0]   rsp_key_hash,
   output logic                          rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FINISH,
      ST_PROBE,
      ST_COMPARE,
      ST_OUT
   } state_type;

   state_type                     state_ff, state_in;
   logic [chrl_pkg::HASH_W-1:0]   accum_ff, accum_in;
   logic [chrl_pkg::HASH_W-1:0]   hash_ff, hash_in;
   logic [chrl_pkg::CNT_W-1:0]    lo_ff, lo_in;
   logic [chrl_pkg::CNT_W-1:0]    hi_ff, hi_in;
   logic                          empty_ff, empty_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [chrl_pkg::SERVER_W-1:0] rsp_server_ff, rsp_server_in;
   logic [chrl_pkg::HASH_W-1:0]   rsp_hash_ff, rsp_hash_in;
   logic                          rsp_status_ff, rsp_status_in;

   chrl_pkg::ring_cmd_type        cmd;
   logic [chrl_pkg::IDX_W-1:0]    rd_addr;
   logic [chrl_pkg::HASH_W-1:0]   rd_value;
   logic [chrl_pkg::SERVER_W-1:0] rd_server;
   logic [chrl_pkg::CNT_W-1:0]    count;
   logic                          accept;
   logic                          searching;
   logic [chrl_pkg::CNT_W-1:0]    mid;
   logic [chrl_pkg::IDX_W-1:0]    final_idx;
   logic [chrl_pkg::HASH_W-1:0]   mixed;
   logic                          slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cmd.clear  = accept && (req_type == chrl_pkg::REQ_CLEAR);
   assign cmd.load   = accept && (req_type == chrl_pkg::REQ_LOAD);
   assign cmd.value  = req_point_value;
   assign cmd.server = req_point_server;

   // search window and probe address
   assign searching = (lo_ff < hi_ff);
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign final_idx = (hi_ff >= count) ? '0 : hi_ff[chrl_pkg::IDX_W-1:0];
   assign rd_addr   = searching ? mid[chrl_pkg::IDX_W-1:0] : final_idx;

   assign mixed = chrl_pkg::mix_byte(accum_ff, req_key_byte);

   chrl_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .rd_value  (rd_value),
      .rd_server (rd_server),
      .count     (count)
   );

   always_comb begin
      state_in      = state_ff;
      accum_in      = accum_ff;
      hash_in       = hash_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      empty_in      = empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_server_in = rsp_server_ff;
      rsp_hash_in   = rsp_hash_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == chrl_pkg::REQ_KEY)) begin
               if (req_key_last) begin
                  hash_in  = mixed;
                  accum_in = '0;
                  state_in = ST_FINISH;
               end else begin
                  accum_in = mixed;
               end
            end
         end
         ST_FINISH: begin
            hash_in  = chrl_pkg::finish_hash(hash_ff);
            lo_in    = '0;
            hi_in    = count;
            empty_in = (count == '0);
            state_in = (count == '0) ? ST_OUT : ST_PROBE;
         end
         ST_PROBE: begin
            state_in = searching ? ST_COMPARE : ST_OUT;
         end
         ST_COMPARE: begin
            if (rd_value < hash_ff) begin
               lo_in = mid + chrl_pkg::CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_PROBE;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hash_in   = hash_ff;
               rsp_server_in = empty_ff ? '0 : rd_server;
               rsp_status_in = empty_ff ? chrl_pkg::STATUS_EMPTY
                                        : chrl_pkg::STATUS_FOUND;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         accum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hash_ff       <= hash_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      empty_ff      <= empty_in;
      rsp_server_ff <= rsp_server_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_server_id = rsp_server_ff;
   assign rsp_key_hash  = rsp_hash_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
